// File: sv/linear_probe_hash_insert_macros.svh
// Assertion macros for the linear-probe hash insert block.
// No dependencies; included by linear_probe_hash_insert, which checks its own logic.
`ifndef LINEAR_PROBE_HASH_INSERT_MACROS_SVH
`define LINEAR_PROBE_HASH_INSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LPHI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lphi: same-cycle check failed");
`define LPHI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lphi: next-cycle check failed");
`else
`define LPHI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LPHI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/lphi_pkg.sv
// Shared constants and types for the linear-probe hash insert block.
// No dependencies.
package lphi_pkg;

   localparam int TABLE_SIZE  = 128;
   localparam int SLOT_W      = 7;
   localparam int KEY_W       = 31;
   localparam int DIV_W       = 8;
   localparam int PROBE_W     = 7;
   localparam int STATUS_W    = 2;
   localparam int OCC_W       = 8;
   localparam int DIVIDEND_W  = 32;
   localparam int DIV_RADIX_W = 4;
   localparam int DIV_STEPS   = DIVIDEND_W / DIV_RADIX_W;
   localparam int STEP_W      = 3;

   localparam logic REG_DIVISOR   = 1'b0;
   localparam logic [DIV_W-1:0] DIVISOR_RESET = 8'd128;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_STORED = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_ZERO   = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_PROBE = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

// File: sv/linear_probe_hash_insert.sv
// Linear-probe hash insert: modulo home slot, probe walk over a key memory.
// Depends on lphi_pkg and linear_probe_hash_insert_macros.svh.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  key_value
//   rsp      out  rsp_tvalid/rsp_tready  slot, probe_count; status in tuser
//   csr      in   APB write/read         divisor at byte address 0
//
// After reset a clearing pass writes zero to all 128 memory entries.
// A key goes through the radix-16 remainder steps, then a probe walk over the
// registered memory read data, then its result loads the output register.
// Zero keys and a full table skip the remainder and probe walk.
// A waiting result holds the next one in the finish state.
`include "linear_probe_hash_insert_macros.svh"

module linear_probe_hash_insert (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [30:0] key_value, [31] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [6:0] slot, [13:7] probe_count, [15:14] zero
   output logic [1:0]  rsp_tuser,    // [1:0] status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   lphi_pkg::state_type state_ff, state_in;

   logic [lphi_pkg::SLOT_W-1:0]     clr_addr_ff, clr_addr_in;
   logic [lphi_pkg::DIV_W-1:0]      divisor_ff, divisor_in;
   logic [lphi_pkg::OCC_W-1:0]      occ_ff, occ_in;
   logic                            chk_valid_ff, chk_valid_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic [lphi_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [lphi_pkg::DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [lphi_pkg::DIV_W-1:0]      rem_ff, rem_in;
   logic [lphi_pkg::DIV_W-1:0]      dsr_ff, dsr_in;
   logic [lphi_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [lphi_pkg::SLOT_W-1:0]     issue_addr_ff, issue_addr_in;
   logic [lphi_pkg::SLOT_W-1:0]     chk_addr_ff, chk_addr_in;
   logic [lphi_pkg::PROBE_W-1:0]    probe_ff, probe_in;
   logic [lphi_pkg::SLOT_W-1:0]     res_slot_ff, res_slot_in;
   lphi_pkg::status_type            res_status_ff, res_status_in;
   logic [lphi_pkg::PROBE_W-1:0]    res_probe_ff, res_probe_in;
   logic [lphi_pkg::SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   lphi_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [lphi_pkg::PROBE_W-1:0]    rsp_probe_ff, rsp_probe_in;

   logic [lphi_pkg::KEY_W-1:0]      key_mem [lphi_pkg::TABLE_SIZE];
   logic [lphi_pkg::KEY_W-1:0]      rd_data_ff;
   logic                            mem_we, mem_re;
   logic [lphi_pkg::SLOT_W-1:0]     mem_waddr;
   logic [lphi_pkg::KEY_W-1:0]      mem_wdata;

   logic                            req_accept, csr_write, out_free, probe_hit;
   logic [lphi_pkg::DIV_W-1:0]      eff_divisor, rem_step;
   logic [lphi_pkg::SLOT_W-1:0]     issue_addr_next;

   assign req_tready = (state_ff == lphi_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == lphi_pkg::REG_DIVISOR) ?
                       {24'd0, divisor_ff} : 32'd0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_probe_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign eff_divisor = (divisor_ff == '0 ||
                         divisor_ff > lphi_pkg::DIV_W'(lphi_pkg::TABLE_SIZE)) ?
                        lphi_pkg::DIV_W'(lphi_pkg::TABLE_SIZE) : divisor_ff;

   assign probe_hit = (state_ff == lphi_pkg::ST_PROBE) && chk_valid_ff &&
                      (rd_data_ff == '0);
   assign issue_addr_next = (issue_addr_ff == lphi_pkg::SLOT_W'(lphi_pkg::TABLE_SIZE - 1)) ?
                            '0 : issue_addr_ff + 1'b1;

   // four restoring remainder steps per cycle
   always_comb begin
      rem_step = rem_ff;
      for (int i = 0; i < lphi_pkg::DIV_RADIX_W; i++) begin
         rem_step = {rem_step[lphi_pkg::DIV_W-2:0], dvd_ff[lphi_pkg::DIVIDEND_W-1-i]};
         if (rem_step >= dsr_ff) begin
            rem_step = rem_step - dsr_ff;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      divisor_in    = divisor_ff;
      occ_in        = occ_ff;
      chk_valid_in  = chk_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      key_in        = key_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      dsr_in        = dsr_ff;
      step_in       = step_ff;
      issue_addr_in = issue_addr_ff;
      chk_addr_in   = chk_addr_ff;
      probe_in      = probe_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      res_probe_in  = res_probe_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_probe_in  = rsp_probe_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = chk_addr_ff;
      mem_wdata     = key_ff;

      if (csr_write && csr_paddr[2] == lphi_pkg::REG_DIVISOR) begin
         divisor_in = csr_pwdata[lphi_pkg::DIV_W-1:0];
      end

      case (state_ff)
         lphi_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == lphi_pkg::SLOT_W'(lphi_pkg::TABLE_SIZE - 1)) begin
               state_in = lphi_pkg::ST_IDLE;
            end
         end
         lphi_pkg::ST_IDLE: begin
            if (req_accept) begin
               key_in       = req_tdata[lphi_pkg::KEY_W-1:0];
               res_slot_in  = '0;
               res_probe_in = '0;
               if (req_tdata[lphi_pkg::KEY_W-1:0] == '0) begin
                  res_status_in = lphi_pkg::STATUS_ZERO;
                  state_in      = lphi_pkg::ST_DONE;
               end else if (occ_ff >= lphi_pkg::OCC_W'(lphi_pkg::TABLE_SIZE)) begin
                  res_status_in = lphi_pkg::STATUS_FULL;
                  state_in      = lphi_pkg::ST_DONE;
               end else begin
                  dvd_in   = {1'b0, req_tdata[lphi_pkg::KEY_W-1:0]};
                  rem_in   = '0;
                  dsr_in   = eff_divisor;
                  step_in  = '0;
                  state_in = lphi_pkg::ST_DIV;
               end
            end
         end
         lphi_pkg::ST_DIV: begin
            rem_in  = rem_step;
            dvd_in  = {dvd_ff[lphi_pkg::DIVIDEND_W-lphi_pkg::DIV_RADIX_W-1:0],
                       {lphi_pkg::DIV_RADIX_W{1'b0}}};
            step_in = step_ff + 1'b1;
            if (step_ff == lphi_pkg::STEP_W'(lphi_pkg::DIV_STEPS - 1)) begin
               issue_addr_in = rem_step[lphi_pkg::SLOT_W-1:0];
               chk_valid_in  = 1'b0;
               probe_in      = '0;
               state_in      = lphi_pkg::ST_PROBE;
            end
         end
         lphi_pkg::ST_PROBE: begin
            if (probe_hit) begin
               mem_we        = 1'b1;
               res_slot_in   = chk_addr_ff;
               res_probe_in  = probe_ff;
               res_status_in = lphi_pkg::STATUS_STORED;
               occ_in        = occ_ff + 1'b1;
               chk_valid_in  = 1'b0;
               state_in      = lphi_pkg::ST_DONE;
            end else begin
               mem_re        = 1'b1;
               chk_addr_in   = issue_addr_ff;
               chk_valid_in  = 1'b1;
               issue_addr_in = issue_addr_next;
               if (chk_valid_ff) begin
                  probe_in = probe_ff + 1'b1;
               end
            end
         end
         lphi_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = res_slot_ff;
               rsp_status_in = res_status_ff;
               rsp_probe_in  = res_probe_ff;
               state_in      = lphi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lphi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lphi_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         divisor_ff   <= lphi_pkg::DIVISOR_RESET;
         occ_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         divisor_ff   <= divisor_in;
         occ_ff       <= occ_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      dsr_ff        <= dsr_in;
      step_ff       <= step_in;
      issue_addr_ff <= issue_addr_in;
      chk_addr_ff   <= chk_addr_in;
      probe_ff      <= probe_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      res_probe_ff  <= res_probe_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_probe_ff  <= rsp_probe_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= key_mem[issue_addr_ff];
      end
   end

`LPHI_ASSERT_IMPL(a_occ_bound, clock, reset, 1'b1, occ_ff <= lphi_pkg::OCC_W'(lphi_pkg::TABLE_SIZE))
`LPHI_ASSERT_NEXT(a_hit_commit, clock, reset, probe_hit, state_ff == lphi_pkg::ST_DONE && occ_ff == $past(occ_ff) + 1'b1)
`LPHI_ASSERT_IMPL(a_write_src, clock, reset, mem_we, state_ff == lphi_pkg::ST_CLEAR || probe_hit)
`LPHI_ASSERT_NEXT(a_accept_route, clock, reset, req_tvalid && req_tready, state_ff == lphi_pkg::ST_DIV || state_ff == lphi_pkg::ST_DONE)

endmodule

// File: tb/tb_linear_probe_hash_insert.sv
`timescale 1ns / 100ps
// Self-checking testbench for linear_probe_hash_insert: random key streams under
// bursty sender and stalling receiver, divisor changes over APB between phases.
// Depends on lphi_pkg and the linear_probe_hash_insert RTL.
module tb_linear_probe_hash_insert;

   typedef struct packed {
      logic [lphi_pkg::SLOT_W-1:0]  slot;
      lphi_pkg::status_type         status;
      logic [lphi_pkg::PROBE_W-1:0] probes;
   } insert_result_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_SPARSE,
      READY_PATTERN
   } ready_mode_type;

   localparam logic [2:0] DIVISOR_ADDR = {lphi_pkg::REG_DIVISOR, 2'b00};
   localparam int MAX_REPORTS = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [30:0] key_value, [31] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [6:0] slot, [13:7] probe_count, [15:14] zero
   logic [1:0]  rsp_tuser;         // [1:0] status
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [lphi_pkg::KEY_W-1:0] pending_keys[$];
   insert_result_type          expected_inserts[$];
   int                         keys_outstanding = 0;
   int                         error_count = 0;
   bit                         req_taken = 1'b0;

   logic [lphi_pkg::KEY_W-1:0] shadow_table[lphi_pkg::TABLE_SIZE];
   int unsigned                shadow_occupied = 0;
   logic [lphi_pkg::DIV_W-1:0] shadow_divisor = lphi_pkg::DIVISOR_RESET;

   int             burst_left = 0;
   int             gap_left = 0;
   int             ready_tick = 0;
   ready_mode_type ready_mode = READY_ALWAYS;

   insert_result_type want;
   insert_result_type got;

   linear_probe_hash_insert dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic insert_result_type predict_insert(input logic [lphi_pkg::KEY_W-1:0] key);
      insert_result_type r;
      int unsigned       home_div;
      int unsigned       pos;
      r.slot   = '0;
      r.probes = '0;
      r.status = lphi_pkg::STATUS_STORED;
      if (key == '0) begin
         r.status = lphi_pkg::STATUS_ZERO;
         return r;
      end
      if (shadow_occupied >= lphi_pkg::TABLE_SIZE) begin
         r.status = lphi_pkg::STATUS_FULL;
         return r;
      end
      if (shadow_divisor == '0 || shadow_divisor > lphi_pkg::TABLE_SIZE)
         home_div = lphi_pkg::TABLE_SIZE;
      else home_div = shadow_divisor;
      pos = key % home_div;
      for (int p = 0; p < lphi_pkg::TABLE_SIZE; p++) begin
         if (shadow_table[pos] == '0) begin
            shadow_table[pos] = key;
            shadow_occupied++;
            r.slot   = pos[lphi_pkg::SLOT_W-1:0];
            r.probes = p[lphi_pkg::PROBE_W-1:0];
            return r;
         end
         pos = (pos + 1) % lphi_pkg::TABLE_SIZE;
      end
      r.status = lphi_pkg::STATUS_FULL;
      return r;
   endfunction

   // sender: bursts of random length, random gaps in between
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_taken = 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_keys.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {1'b0, pending_keys.pop_front()};
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern is re-drawn at random from four modes
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         ready_tick++;
         if (ready_tick % 80 == 0) ready_mode = ready_mode_type'($urandom_range(0, 3));
         case (ready_mode)
            READY_ALWAYS:  rsp_tready <= 1'b1;
            READY_RANDOM:  rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE:  rsp_tready <= ($urandom_range(0, 3) == 0);
            default:       rsp_tready <= (ready_tick % 5 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_inserts.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("ERROR %0t: response with nothing pending: tdata %h tuser %h",
                           $realtime, rsp_tdata, rsp_tuser);
            end else begin
               want = expected_inserts.pop_front();
               keys_outstanding--;
               got.slot   = rsp_tdata[6:0];
               got.probes = rsp_tdata[13:7];
               got.status = lphi_pkg::status_type'(rsp_tuser);
               if (got !== want) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("ERROR %0t: exp slot %0d status %0d probes %0d", $realtime,
                              want.slot, want.status, want.probes);
                     $display("          got slot %0d status %0d probes %0d",
                              got.slot, got.status, got.probes);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_inserts.push_back(predict_insert(req_tdata[lphi_pkg::KEY_W-1:0]));
            req_taken = 1'b1;
         end
      end
   end

   task automatic queue_key(input logic [lphi_pkg::KEY_W-1:0] key);
      pending_keys.push_back(key);
      keys_outstanding++;
   endtask

   task automatic wait_idle();
      while (keys_outstanding != 0) @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= DIVISOR_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_divisor_readback();
      logic [31:0] rdata;
      csr_access(1'b0, '0, rdata);
      if (rdata[lphi_pkg::DIV_W-1:0] !== shadow_divisor) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("ERROR %0t: divisor readback exp %0d got %0d", $realtime,
                     shadow_divisor, rdata[lphi_pkg::DIV_W-1:0]);
      end
   endtask

   task automatic set_divisor(input logic [lphi_pkg::DIV_W-1:0] value);
      logic [31:0] rdata;
      wait_idle();
      csr_access(1'b1, {24'd0, value}, rdata);
      shadow_divisor = value;
      check_divisor_readback();
   endtask

   initial begin
      #(64'd10_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [lphi_pkg::KEY_W-1:0] key;
      int                         count;
      for (int i = 0; i < lphi_pkg::TABLE_SIZE; i++) shadow_table[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      check_divisor_readback();

      // zero key, key extremes, wrap past the last slot, duplicates
      queue_key(31'd0);
      queue_key(31'h7FFF_FFFF);
      queue_key(31'd127);
      queue_key(31'd1);
      queue_key(31'd1);
      queue_key(31'd128);
      queue_key(31'h4000_0000);
      queue_key(31'h2AAA_AAAA);
      queue_key(31'h5555_5555);
      set_divisor(8'd1);
      queue_key(31'd5);
      queue_key(31'd77);
      queue_key(31'h7FFF_FFFF);
      queue_key(31'd0);
      set_divisor(8'd0);
      queue_key(31'd300);
      queue_key(31'd44);
      set_divisor(8'd255);
      queue_key(31'd254);
      set_divisor(8'd129);
      queue_key(31'd128);
      queue_key(31'h0123_4567);

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0:       set_divisor(8'd7);
            1:       set_divisor(8'd1);
            2:       set_divisor(8'd128);
            3:       set_divisor(8'd0);
            4:       set_divisor(8'd255);
            5:       set_divisor(8'd64);
            default: set_divisor(8'($urandom_range(2, 200)));
         endcase
         count = $urandom_range(80, 120);
         for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 5) != 0) begin
               key = '0;
            end else if ($urandom_range(0, 1) == 0) begin
               key = 31'($urandom_range(1, 400));
            end else begin
               key = 31'($urandom());
               if (key == '0) key = 31'd1;
            end
            queue_key(key);
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_inserts.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
